@@ rtl/core/ccpd_pkg.sv @@
package ccpd_pkg;

    localparam int PIXELS_PER_CELL = 16;
    localparam int PIX_IDX_W       = $clog2(PIXELS_PER_CELL);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int ROW_W    = 7;
    localparam int MA_W     = 14;
    localparam int RA_W     = 3;
    localparam int WORD_W   = 16;
    localparam int PEN_W    = 4;
    localparam int ADDR_W   = 16;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_DISP   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;
    localparam logic [ROW_W-1:0]  VDISP_RESET = 7'd25;

    localparam logic [MODE_W-1:0] MODE_4BPP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_2BPP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_1BPP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic [PIX_IDX_W-1:0] LAST_PIX = PIX_IDX_W'(PIXELS_PER_CELL - 1);

    typedef struct packed {
        logic              border;
        logic [MODE_W-1:0] mode;
        logic [WORD_W-1:0] word;
        logic [ADDR_W-1:0] addr;
        logic              line_end;
    } t_cmd;

    typedef struct packed {
        logic [PEN_W-1:0]  pen;
        logic              is_border;
        logic [ADDR_W-1:0] fetch_address;
        logic              cell_last;
        logic              line_last;
    } t_pix;

    function automatic logic [ADDR_W-1:0] make_address(input logic [MA_W-1:0] ma,
                                                       input logic [RA_W-1:0] ra);
        return {ma[13:12], ra, ma[9:0], 1'b0};
    endfunction

    function automatic logic [PEN_W-1:0] decode_pen(input logic [MODE_W-1:0]    mode,
                                                    input logic [WORD_W-1:0]    word,
                                                    input logic [PIX_IDX_W-1:0] idx);
        logic [7:0] b;
        logic       k0;
        logic [1:0] k1;
        logic [PEN_W-1:0] pen;
        pen = '0;
        case (mode)
            MODE_4BPP: begin
                b   = idx[3] ? word[7:0] : word[15:8];
                k0  = idx[2];
                pen = {b[3'd1 - {2'b00, k0}], b[3'd5 - {2'b00, k0}],
                       b[3'd3 - {2'b00, k0}], b[3'd7 - {2'b00, k0}]};
            end
            MODE_2BPP: begin
                b   = idx[3] ? word[7:0] : word[15:8];
                k1  = idx[2:1];
                pen = {2'b00, b[3'd3 - {1'b0, k1}], b[3'd7 - {1'b0, k1}]};
            end
            default: begin
                b   = '0;
                pen = {3'b000, word[4'd15 - idx]};
            end
        endcase
        return pen;
    endfunction

endpackage

@@ rtl/core/ccpd_cell_if.sv @@
interface ccpd_cell_if;
    logic                           valid;
    logic                           ready;
    logic [ccpd_pkg::ROW_W-1:0]     char_row;
    logic [ccpd_pkg::MA_W-1:0]      ma;
    logic [ccpd_pkg::RA_W-1:0]      ra;
    logic [ccpd_pkg::WORD_W-1:0]    video_word;
    logic                           in_vsync;
    logic                           line_end;

    modport source (output valid, char_row, ma, ra, video_word, in_vsync, line_end,
                    input ready);
    modport sink   (input valid, char_row, ma, ra, video_word, in_vsync, line_end,
                    output ready);
endinterface

@@ rtl/core/ccpd_pix_if.sv @@
interface ccpd_pix_if;
    logic                           valid;
    logic                           ready;
    logic [ccpd_pkg::PEN_W-1:0]     pen;
    logic                           is_border;
    logic [ccpd_pkg::ADDR_W-1:0]    fetch_address;
    logic                           cell_last;
    logic                           line_last;

    modport source (output valid, pen, is_border, fetch_address, cell_last, line_last,
                    input ready);
    modport sink   (input valid, pen, is_border, fetch_address, cell_last, line_last,
                    output ready);
endinterface

@@ rtl/core/crtc_char_cell_pixel_decoder.sv @@
// Character-cell pixel decoder.
// i_cell: one transaction per character cell (row, ma, ra, video word, vsync,
//   line end). o_pix: one transaction per pixel, sixteen per drawn cell, in
//   order, with cell_last on the sixteenth and line_last on it for the line's
//   last cell. Cells in vsync, and displayed cells in the unused mode, are
//   consumed and yield nothing.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 screen mode,
//   1 vertical displayed); write only while no cell is in flight.
// Cells pass the command queue and command register; each pixel is registered.
// Throughput: one pixel per cycle while o_pix is not stalled, set by the
//   pixel counter in the back end; consecutive cells run with no gap.
// A two-entry command queue between classifier and pixel sequencer lets cells
//   be accepted while pixels are still being sent; i_cell.ready drops when the
//   queue is full. A stalled o_pix holds its pixel in the output register and
//   the sequencer waits.
// Reset (synchronous, active low) empties the queue and the sequencer and sets
//   screen mode 1, vertical displayed 25.
module crtc_char_cell_pixel_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ccpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ccpd_cell_if.sink                         i_cell,
    ccpd_pix_if.source                        o_pix
);

    logic           q_push, q_ready, q_pop, q_valid;
    ccpd_pkg::t_cmd q_cmd_in, q_cmd_out;

    ccpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (i_cell),
        .i_q_ready  (q_ready),
        .o_q_push   (q_push),
        .o_q_cmd    (q_cmd_in)
    );

    ccpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd_in),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd_out)
    );

    ccpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd_out),
        .o_q_pop   (q_pop),
        .o_pix     (o_pix)
    );

endmodule

@@ rtl/core/ccpd_front.sv @@
module ccpd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ccpd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ccpd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ccpd_cell_if.sink                         i_cell,
    input  logic                              i_q_ready,
    output logic                              o_q_push,
    output ccpd_pkg::t_cmd                    o_q_cmd
);

    logic [ccpd_pkg::MODE_W-1:0] r_mode;
    logic [ccpd_pkg::ROW_W-1:0]  r_vdisp;
    logic                        border;
    logic                        drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ccpd_pkg::MODE_RESET;
            r_vdisp <= ccpd_pkg::VDISP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ccpd_pkg::CFG_SCREEN_MODE)
                r_mode <= i_cfg_data[ccpd_pkg::MODE_W-1:0];
            if (i_cfg_idx == ccpd_pkg::CFG_VERT_DISP)
                r_vdisp <= i_cfg_data[ccpd_pkg::ROW_W-1:0];
        end
    end

    // vsync cells and displayed cells in the unused mode are swallowed here
    always_comb begin
        border = (i_cell.char_row >= r_vdisp);
        drop   = i_cell.in_vsync || (!border && (r_mode == ccpd_pkg::MODE_NONE));

        o_q_cmd.border   = border;
        o_q_cmd.mode     = r_mode;
        o_q_cmd.word     = i_cell.video_word;
        o_q_cmd.addr     = border ? '0 : ccpd_pkg::make_address(i_cell.ma, i_cell.ra);
        o_q_cmd.line_end = i_cell.line_end;
    end

    assign i_cell.ready = i_q_ready;
    assign o_q_push     = i_cell.valid && i_q_ready && !drop;

endmodule

@@ rtl/core/ccpd_queue.sv @@
module ccpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ccpd_pkg::t_cmd  i_cmd,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output ccpd_pkg::t_cmd  o_cmd
);

    ccpd_pkg::t_cmd                     r_mem [ccpd_pkg::QUEUE_DEPTH];
    logic [ccpd_pkg::QUEUE_PTR_W-1:0]   r_wr, n_wr;
    logic [ccpd_pkg::QUEUE_PTR_W-1:0]   r_rd, n_rd;
    logic [ccpd_pkg::QUEUE_CNT_W-1:0]   r_count, n_count;
    logic                               do_push, do_pop;

    localparam logic [ccpd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        ccpd_pkg::QUEUE_PTR_W'(ccpd_pkg::QUEUE_DEPTH - 1);
    localparam logic [ccpd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        ccpd_pkg::QUEUE_CNT_W'(ccpd_pkg::QUEUE_DEPTH);

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = do_push ? ((r_wr == PTR_LAST) ? '0 : r_wr + 1'b1) : r_wr;
        n_rd    = do_pop  ? ((r_rd == PTR_LAST) ? '0 : r_rd + 1'b1) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop)
            n_count = r_count + 1'b1;
        else if (!do_push && do_pop)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_cmd;
    end

endmodule

@@ rtl/core/ccpd_back.sv @@
module ccpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ccpd_pkg::t_cmd  i_q_cmd,
    output logic            o_q_pop,
    ccpd_pix_if.source      o_pix
);

    ccpd_pkg::t_cmd                     r_cmd;
    logic                               r_busy, n_busy;
    logic [ccpd_pkg::PIX_IDX_W-1:0]     r_idx, n_idx;
    logic                               r_out_valid, n_out_valid;
    ccpd_pkg::t_pix                     r_out, n_out;
    logic                               can_load;
    logic                               emit;
    logic                               at_last;

    always_comb begin
        can_load = !r_out_valid || o_pix.ready;
        emit     = r_busy && can_load;
        at_last  = (r_idx == ccpd_pkg::LAST_PIX);
        // next cell is taken on the same edge as the last pixel of this one
        o_q_pop  = i_q_valid && (!r_busy || (emit && at_last));

        n_out_valid = r_out_valid && !o_pix.ready;
        n_out       = r_out;
        n_idx       = r_idx;
        n_busy      = r_busy;
        if (emit) begin
            n_out_valid         = 1'b1;
            n_out.pen           = r_cmd.border ? '0 :
                                  ccpd_pkg::decode_pen(r_cmd.mode, r_cmd.word, r_idx);
            n_out.is_border     = r_cmd.border;
            n_out.fetch_address = r_cmd.addr;
            n_out.cell_last     = at_last;
            n_out.line_last     = at_last && r_cmd.line_end;
            n_idx               = r_idx + 1'b1;
            if (at_last)
                n_busy = 1'b0;
        end
        if (o_q_pop) begin
            n_busy = 1'b1;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (o_q_pop)
            r_cmd <= i_q_cmd;
    end

    assign o_pix.valid         = r_out_valid;
    assign o_pix.pen           = r_out.pen;
    assign o_pix.is_border     = r_out.is_border;
    assign o_pix.fetch_address = r_out.fetch_address;
    assign o_pix.cell_last     = r_out.cell_last;
    assign o_pix.line_last     = r_out.line_last;

    a_border_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.is_border |-> r_out.pen == '0 && r_out.fetch_address == '0)
        else $error("border pixel carries pen or address");

    a_line_in_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.line_last |-> r_out.cell_last)
        else $error("line_last without cell_last");

    a_cell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && at_last && !i_q_valid |=> !r_busy && r_out_valid && r_out.cell_last)
        else $error("cell did not retire after its last pixel");

    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_busy && r_idx == '0)
        else $error("new cell did not start at pixel zero");

endmodule
